// ===== design/xml_entity_decoder_utf8_top_defines.svh =====
// Assertion macros shared by the decoder modules.
`ifndef XML_ENTITY_DECODER_UTF8_TOP_DEFINES_SVH
`define XML_ENTITY_DECODER_UTF8_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define XED_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define XED_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/xed_pkg.sv =====
package xed_pkg;

    // Longest reference, '&' through ';', that the buffer can hold.
    localparam int REF_WINDOW = 32;
    localparam int PTR_W      = $clog2(REF_WINDOW);
    localparam int CNT_W      = $clog2(REF_WINDOW + 1);

    // Code point thresholds for the UTF-8 forms.
    localparam logic [31:0] CP_2B    = 32'h0000_0080;
    localparam logic [31:0] CP_3B    = 32'h0000_0800;
    localparam logic [31:0] CP_4B    = 32'h0001_0000;
    localparam logic [31:0] CP_LIMIT = 32'h0011_0000;

    // UTF-8 lead and continuation marks.
    localparam logic [7:0] LEAD2 = 8'hC0;
    localparam logic [7:0] LEAD3 = 8'hE0;
    localparam logic [7:0] LEAD4 = 8'hF0;
    localparam logic [7:0] CONT  = 8'h80;

    // Characters the scanner looks for.
    localparam logic [7:0] CH_AMP  = "&";
    localparam logic [7:0] CH_SEMI = ";";
    localparam logic [7:0] CH_HASH = "#";
    localparam logic [7:0] CH_0    = "0";
    localparam logic [7:0] CH_9    = "9";
    localparam logic [7:0] CH_LA   = "a";
    localparam logic [7:0] CH_LF   = "f";
    localparam logic [7:0] CH_UA   = "A";
    localparam logic [7:0] CH_UF   = "F";
    localparam logic [7:0] CH_LX   = "x";
    localparam logic [7:0] CH_UX   = "X";
    localparam logic [7:0] CH_LT   = "<";
    localparam logic [7:0] CH_GT   = ">";
    localparam logic [7:0] CH_QUOT = 8'h22;
    localparam logic [7:0] CH_APOS = 8'h27;

    // Entity names.
    localparam logic [15:0] NM_LT   = "lt";
    localparam logic [15:0] NM_GT   = "gt";
    localparam logic [23:0] NM_AMP  = "amp";
    localparam logic [31:0] NM_QUOT = "quot";
    localparam logic [31:0] NM_APOS = "apos";

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_HEAD,
        ST_EV_RD,
        ST_EV_DAT,
        ST_EV_END,
        ST_EMIT_REF,
        ST_FLUSH
    } xed_state_t;

    // Source of an emitted byte.
    typedef enum logic [1:0] {
        SEL_HEAD,
        SEL_AMP,
        SEL_REF
    } xed_sel_t;

    typedef struct packed {
        logic     push;
        logic     fast;
        logic     rd_head;
        logic     pop;
        logic     clear;
        logic     ev_start;
        logic     ev_rd;
        logic     ev_step;
        logic     emit;
        xed_sel_t emit_sel;
        logic [1:0] ref_idx;
        logic     flush;
    } xed_cmd_t;

    typedef struct packed {
        logic       count_zero;
        logic       count_full;
        logic       head_amp;
        logic       term;
        logic       last;
        logic       name_done;
        logic       ref_ok;
        logic [1:0] ref_last_idx;
        logic       stage_valid;
        logic       out_free;
        logic       fast_ok;
    } xed_sts_t;

    typedef struct packed {
        logic [1:0]      last_idx;
        logic [3:0][7:0] bytes;
    } xed_utf8_t;

    // UTF-8 form of a code point below CP_LIMIT.
    function automatic xed_utf8_t utf8_encode(input logic [31:0] cp);
        xed_utf8_t r;
        r = '0;
        if (cp < CP_2B) begin
            r.last_idx = 2'd0;
            r.bytes[0] = cp[7:0];
        end else if (cp < CP_3B) begin
            r.last_idx = 2'd1;
            r.bytes[0] = LEAD2 | {3'b000, cp[10:6]};
            r.bytes[1] = CONT | {2'b00, cp[5:0]};
        end else if (cp < CP_4B) begin
            r.last_idx = 2'd2;
            r.bytes[0] = LEAD3 | {4'b0000, cp[15:12]};
            r.bytes[1] = CONT | {2'b00, cp[11:6]};
            r.bytes[2] = CONT | {2'b00, cp[5:0]};
        end else begin
            r.last_idx = 2'd3;
            r.bytes[0] = LEAD4 | {5'b00000, cp[20:18]};
            r.bytes[1] = CONT | {2'b00, cp[17:12]};
            r.bytes[2] = CONT | {2'b00, cp[11:6]};
            r.bytes[3] = CONT | {2'b00, cp[5:0]};
        end
        return r;
    endfunction

    // Circular buffer pointer plus an offset of at most REF_WINDOW.
    function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] ptr,
                                                 input logic [CNT_W-1:0] n);
        logic [CNT_W:0] sum;
        sum = {{(CNT_W + 1 - PTR_W){1'b0}}, ptr} + {1'b0, n};
        if (sum >= (CNT_W + 1)'(REF_WINDOW)) begin
            sum = sum - (CNT_W + 1)'(REF_WINDOW);
        end
        return sum[PTR_W-1:0];
    endfunction

endpackage

// ===== design/xed_datapath.sv =====
`include "xml_entity_decoder_utf8_top_defines.svh"

module xed_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        data_byte,
    input  logic              in_last,
    input  xed_pkg::xed_cmd_t cmd,
    output xed_pkg::xed_sts_t sts,
    input  logic              out_ready,
    output logic              out_valid,
    output logic [7:0]        out_byte,
    output logic              run_done,
    output logic              text_done
);

    // Held bytes of an open reference, kept as a circular buffer.
    logic [7:0] held_mem [xed_pkg::REF_WINDOW];
    logic [7:0] rd_data_reg;

    logic [xed_pkg::PTR_W-1:0] head_reg, head_next;
    logic [xed_pkg::CNT_W-1:0] count_reg, count_next;
    logic                      last_reg, last_next;
    logic                      term_reg, term_next;
    logic [xed_pkg::PTR_W-1:0] tail;
    logic [xed_pkg::PTR_W-1:0] rd_addr;

    // Reference parser state.
    logic [xed_pkg::PTR_W-1:0] ev_ptr_reg;
    logic [xed_pkg::CNT_W-1:0] name_left_reg;
    logic [xed_pkg::CNT_W-1:0] name_len_reg;
    logic [xed_pkg::CNT_W-1:0] name_idx_reg;
    logic [31:0]               dec_acc_reg;
    logic [31:0]               hex_acc_reg;
    logic                      dec_bad_reg;
    logic                      hex_bad_reg;
    logic [7:0]                nm_reg [4];

    // Staged byte and output register.
    logic       stage_valid_reg, stage_valid_next;
    logic [7:0] stage_byte_reg;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg;
    logic       run_done_reg;
    logic       text_done_reg;
    logic       out_free;
    logic       out_load;
    logic [7:0] out_load_byte;
    logic       out_load_run;
    logic       out_load_text;
    logic [7:0] emit_byte;

    // Parser byte decode.
    logic        dig_dec;
    logic        dig_hex;
    logic [3:0]  hex_val;
    logic [31:0] dec_mul;

    // Reference result.
    logic                  numeric;
    logic                  is_hex;
    logic [31:0]           cp;
    logic                  num_ok;
    logic                  ref_ok;
    xed_pkg::xed_utf8_t    enc;
    xed_pkg::xed_utf8_t    ref_res;

    assign tail     = xed_pkg::ptr_add(head_reg, count_reg);
    assign rd_addr  = cmd.ev_rd ? ev_ptr_reg : head_reg;
    assign out_free = !out_valid_reg || out_ready;

    // Buffer memory: one write at the tail, one registered read.
    always_ff @(posedge clk)
    begin
        if (cmd.push) begin
            held_mem[tail] <= data_byte;
        end
        if (cmd.rd_head || cmd.ev_rd) begin
            rd_data_reg <= held_mem[rd_addr];
        end
    end

    // Buffer pointers and string flags.
    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        last_next  = last_reg;
        term_next  = term_reg;
        if (cmd.push) begin
            count_next = count_reg + xed_pkg::CNT_W'(1);
            last_next  = in_last;
            term_next  = (data_byte == xed_pkg::CH_SEMI);
        end else if (cmd.clear) begin
            head_next  = tail;
            count_next = '0;
        end else if (cmd.pop) begin
            head_next  = xed_pkg::ptr_add(head_reg, xed_pkg::CNT_W'(1));
            count_next = count_reg - xed_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            head_reg  <= '0;
            count_reg <= '0;
            last_reg  <= 1'b0;
            term_reg  <= 1'b0;
        end else begin
            head_reg  <= head_next;
            count_reg <= count_next;
            last_reg  <= last_next;
            term_reg  <= term_next;
        end
    end

    // Digit classification of the byte being parsed.
    always_comb
    begin
        dig_dec = (rd_data_reg >= xed_pkg::CH_0) && (rd_data_reg <= xed_pkg::CH_9);
        dig_hex = dig_dec
                  || ((rd_data_reg >= xed_pkg::CH_LA) && (rd_data_reg <= xed_pkg::CH_LF))
                  || ((rd_data_reg >= xed_pkg::CH_UA) && (rd_data_reg <= xed_pkg::CH_UF));
        hex_val = dig_dec ? rd_data_reg[3:0] : rd_data_reg[3:0] + 4'd9;
        dec_mul = {dec_acc_reg[28:0], 3'b000} + {dec_acc_reg[30:0], 1'b0}
                  + {28'd0, rd_data_reg[3:0]};
    end

    // Parser: one name byte per step, decimal and hex values in parallel.
    always_ff @(posedge clk)
    begin
        if (cmd.ev_start) begin
            ev_ptr_reg    <= xed_pkg::ptr_add(head_reg, xed_pkg::CNT_W'(1));
            name_left_reg <= count_reg - xed_pkg::CNT_W'(2);
            name_len_reg  <= count_reg - xed_pkg::CNT_W'(2);
            name_idx_reg  <= '0;
            dec_acc_reg   <= '0;
            hex_acc_reg   <= '0;
            dec_bad_reg   <= 1'b0;
            hex_bad_reg   <= 1'b0;
        end else if (cmd.ev_step) begin
            if (name_idx_reg < xed_pkg::CNT_W'(4)) begin
                nm_reg[name_idx_reg[1:0]] <= rd_data_reg;
            end
            if (name_idx_reg >= xed_pkg::CNT_W'(1)) begin
                if (dig_dec) begin
                    dec_acc_reg <= dec_mul;
                end else begin
                    dec_bad_reg <= 1'b1;
                end
            end
            if (name_idx_reg >= xed_pkg::CNT_W'(2)) begin
                if (dig_hex) begin
                    hex_acc_reg <= {hex_acc_reg[27:0], hex_val};
                end else begin
                    hex_bad_reg <= 1'b1;
                end
            end
            ev_ptr_reg    <= xed_pkg::ptr_add(ev_ptr_reg, xed_pkg::CNT_W'(1));
            name_left_reg <= name_left_reg - xed_pkg::CNT_W'(1);
            name_idx_reg  <= name_idx_reg + xed_pkg::CNT_W'(1);
        end
    end

    // Verdict on the parsed name and its output bytes.
    always_comb
    begin
        numeric = (name_len_reg >= xed_pkg::CNT_W'(2)) && (nm_reg[0] == xed_pkg::CH_HASH);
        is_hex  = (nm_reg[1] == xed_pkg::CH_LX) || (nm_reg[1] == xed_pkg::CH_UX);
        cp      = is_hex ? hex_acc_reg : dec_acc_reg;
        num_ok  = is_hex ? ((name_len_reg >= xed_pkg::CNT_W'(3)) && !hex_bad_reg)
                         : !dec_bad_reg;
        enc     = xed_pkg::utf8_encode(cp);
        ref_res = '0;
        ref_ok  = 1'b0;
        if (numeric) begin
            ref_ok  = num_ok && (cp < xed_pkg::CP_LIMIT);
            ref_res = enc;
        end else if (name_len_reg == xed_pkg::CNT_W'(2)) begin
            if ({nm_reg[0], nm_reg[1]} == xed_pkg::NM_LT) begin
                ref_ok           = 1'b1;
                ref_res.bytes[0] = xed_pkg::CH_LT;
            end else if ({nm_reg[0], nm_reg[1]} == xed_pkg::NM_GT) begin
                ref_ok           = 1'b1;
                ref_res.bytes[0] = xed_pkg::CH_GT;
            end
        end else if (name_len_reg == xed_pkg::CNT_W'(3)) begin
            if ({nm_reg[0], nm_reg[1], nm_reg[2]} == xed_pkg::NM_AMP) begin
                ref_ok           = 1'b1;
                ref_res.bytes[0] = xed_pkg::CH_AMP;
            end
        end else if (name_len_reg == xed_pkg::CNT_W'(4)) begin
            if ({nm_reg[0], nm_reg[1], nm_reg[2], nm_reg[3]} == xed_pkg::NM_QUOT) begin
                ref_ok           = 1'b1;
                ref_res.bytes[0] = xed_pkg::CH_QUOT;
            end else if ({nm_reg[0], nm_reg[1], nm_reg[2], nm_reg[3]} == xed_pkg::NM_APOS) begin
                ref_ok           = 1'b1;
                ref_res.bytes[0] = xed_pkg::CH_APOS;
            end
        end
    end

    // Emitted byte source.
    always_comb
    begin
        unique case (cmd.emit_sel)
            xed_pkg::SEL_HEAD: emit_byte = rd_data_reg;
            xed_pkg::SEL_AMP:  emit_byte = xed_pkg::CH_AMP;
            xed_pkg::SEL_REF:  emit_byte = ref_res.bytes[cmd.ref_idx];
            default:           emit_byte = xed_pkg::CH_AMP;
        endcase
    end

    // A byte waits in the stage until it is known whether it ends the run.
    always_comb
    begin
        out_valid_next   = out_valid_reg && !out_ready;
        stage_valid_next = stage_valid_reg;
        out_load         = 1'b0;
        out_load_byte    = stage_byte_reg;
        out_load_run     = 1'b0;
        out_load_text    = 1'b0;
        if (cmd.fast) begin
            out_load      = 1'b1;
            out_load_byte = data_byte;
            out_load_run  = 1'b1;
            out_load_text = in_last;
        end else if (cmd.emit) begin
            out_load         = stage_valid_reg;
            stage_valid_next = 1'b1;
        end else if (cmd.flush && stage_valid_reg && out_free) begin
            out_load         = 1'b1;
            out_load_run     = 1'b1;
            out_load_text    = last_reg;
            stage_valid_next = 1'b0;
        end
        if (out_load) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg   <= 1'b0;
            stage_valid_reg <= 1'b0;
        end else begin
            out_valid_reg   <= out_valid_next;
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit) begin
            stage_byte_reg <= emit_byte;
        end
        if (out_load) begin
            out_byte_reg  <= out_load_byte;
            run_done_reg  <= out_load_run;
            text_done_reg <= out_load_text;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign run_done  = run_done_reg;
    assign text_done = text_done_reg;

    // Status toward the controller.
    always_comb
    begin
        sts.count_zero   = (count_reg == '0);
        sts.count_full   = (count_reg >= xed_pkg::CNT_W'(xed_pkg::REF_WINDOW));
        sts.head_amp     = (rd_data_reg == xed_pkg::CH_AMP);
        sts.term         = term_reg;
        sts.last         = last_reg;
        sts.name_done    = (name_left_reg == '0);
        sts.ref_ok       = ref_ok;
        sts.ref_last_idx = ref_res.last_idx;
        sts.stage_valid  = stage_valid_reg;
        sts.out_free     = out_free;
        sts.fast_ok      = (count_reg == '0) && (data_byte != xed_pkg::CH_AMP);
    end

    // A push never overfills the buffer and a pop never underflows it.
    `XED_ASSERT_IMP(a_push_room, clk, rst_n, cmd.push, count_reg < xed_pkg::CNT_W'(xed_pkg::REF_WINDOW), "push into a full buffer")
    `XED_ASSERT_IMP(a_pop_nonempty, clk, rst_n, cmd.pop, count_reg != '0, "pop from an empty buffer")
    // A staged byte is only displaced when the output register can take it.
    `XED_ASSERT_IMP(a_emit_room, clk, rst_n, cmd.emit, !stage_valid_reg || out_free, "emit overwrote a staged word")

endmodule

// ===== design/xed_ctrl.sv =====
`include "xml_entity_decoder_utf8_top_defines.svh"

module xed_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  xed_pkg::xed_sts_t sts,
    output xed_pkg::xed_cmd_t cmd
);

    xed_pkg::xed_state_t state_reg, state_next;
    logic [1:0]          ref_idx_reg, ref_idx_next;
    logic                emit_ok;
    logic                accept;

    assign emit_ok  = !sts.stage_valid || sts.out_free;
    assign in_ready = (state_reg == xed_pkg::ST_IDLE) && sts.out_free;
    assign accept   = in_valid && in_ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            xed_pkg::ST_IDLE: begin
                if (accept && !sts.fast_ok) begin
                    state_next = xed_pkg::ST_CHECK;
                end
            end
            xed_pkg::ST_CHECK: begin
                state_next = sts.count_zero ? xed_pkg::ST_FLUSH : xed_pkg::ST_HEAD;
            end
            xed_pkg::ST_HEAD: begin
                if (!sts.head_amp) begin
                    if (emit_ok) begin
                        state_next = xed_pkg::ST_CHECK;
                    end
                end else if (sts.term) begin
                    state_next = xed_pkg::ST_EV_RD;
                end else if (sts.count_full || sts.last) begin
                    if (emit_ok) begin
                        state_next = xed_pkg::ST_CHECK;
                    end
                end else begin
                    state_next = xed_pkg::ST_FLUSH;
                end
            end
            xed_pkg::ST_EV_RD: begin
                state_next = sts.name_done ? xed_pkg::ST_EV_END : xed_pkg::ST_EV_DAT;
            end
            xed_pkg::ST_EV_DAT: begin
                state_next = xed_pkg::ST_EV_RD;
            end
            xed_pkg::ST_EV_END: begin
                if (sts.ref_ok) begin
                    state_next = xed_pkg::ST_EMIT_REF;
                end else if (emit_ok) begin
                    state_next = xed_pkg::ST_CHECK;
                end
            end
            xed_pkg::ST_EMIT_REF: begin
                if (emit_ok && (ref_idx_reg == sts.ref_last_idx)) begin
                    state_next = xed_pkg::ST_FLUSH;
                end
            end
            xed_pkg::ST_FLUSH: begin
                if (!sts.stage_valid || sts.out_free) begin
                    state_next = xed_pkg::ST_IDLE;
                end
            end
            default: state_next = xed_pkg::ST_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        cmd          = '0;
        cmd.emit_sel = xed_pkg::SEL_HEAD;
        cmd.ref_idx  = ref_idx_reg;
        unique case (state_reg)
            xed_pkg::ST_IDLE: begin
                if (accept) begin
                    cmd.fast = sts.fast_ok;
                    cmd.push = !sts.fast_ok;
                end
            end
            xed_pkg::ST_CHECK: begin
                cmd.rd_head = !sts.count_zero;
            end
            xed_pkg::ST_HEAD: begin
                if (!sts.head_amp) begin
                    cmd.emit = emit_ok;
                    cmd.pop  = emit_ok;
                end else if (sts.term) begin
                    cmd.ev_start = 1'b1;
                end else if (sts.count_full || sts.last) begin
                    cmd.emit     = emit_ok;
                    cmd.emit_sel = xed_pkg::SEL_AMP;
                    cmd.pop      = emit_ok;
                end
            end
            xed_pkg::ST_EV_RD: begin
                cmd.ev_rd = !sts.name_done;
            end
            xed_pkg::ST_EV_DAT: begin
                cmd.ev_step = 1'b1;
            end
            xed_pkg::ST_EV_END: begin
                if (!sts.ref_ok) begin
                    cmd.emit     = emit_ok;
                    cmd.emit_sel = xed_pkg::SEL_AMP;
                    cmd.pop      = emit_ok;
                end
            end
            xed_pkg::ST_EMIT_REF: begin
                cmd.emit     = emit_ok;
                cmd.emit_sel = xed_pkg::SEL_REF;
                cmd.clear    = emit_ok && (ref_idx_reg == sts.ref_last_idx);
            end
            xed_pkg::ST_FLUSH: begin
                cmd.flush = sts.stage_valid && sts.out_free;
            end
            default: cmd = '0;
        endcase
    end

    // Index of the next decoded reference byte.
    always_comb
    begin
        ref_idx_next = ref_idx_reg;
        if (state_reg == xed_pkg::ST_EV_END) begin
            ref_idx_next = '0;
        end else if ((state_reg == xed_pkg::ST_EMIT_REF) && emit_ok) begin
            ref_idx_next = ref_idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg   <= xed_pkg::ST_IDLE;
            ref_idx_reg <= '0;
        end else begin
            state_reg   <= state_next;
            ref_idx_reg <= ref_idx_next;
        end
    end

    // The stage is always drained before a new word is taken.
    `XED_ASSERT_IMP(a_idle_stage_empty, clk, rst_n, state_reg == xed_pkg::ST_IDLE, !sts.stage_valid, "stage holds a word while idle")
    // At the end of a string nothing stays held.
    `XED_ASSERT_IMP(a_last_buffer_empty, clk, rst_n, (state_reg == xed_pkg::ST_FLUSH) && sts.last, sts.count_zero, "bytes held past end of string")
    // Reference bytes are never read past the encoded length.
    `XED_ASSERT_IMP(a_ref_idx_range, clk, rst_n, state_reg == xed_pkg::ST_EMIT_REF, ref_idx_reg <= sts.ref_last_idx, "reference byte index out of range")

endmodule

// ===== design/xml_entity_decoder_utf8_top.sv =====
// Channel | Signals                                  | Word
// --------+------------------------------------------+----------------------------
// in      | in_valid, in_ready, data_byte, in_last   | one raw text byte
// out     | out_valid, out_ready, out_byte,          | one decoded UTF-8 byte
//         | run_done, text_done                      |
//
// A plain byte with no reference open and a free output register goes straight to
// the output register. Other bytes run through the held-byte memory: each held
// byte scanned passes CHECK and HEAD, each parsed name byte EV_RD and EV_DAT,
// each output byte EMIT_REF, and FLUSH closes; a failed reference rescans up to
// 31 held bytes. Reset clears the control state; the held-byte memory is not
// cleared. A byte is taken only while the output register is free; emission
// stalls once the stage is full and the output register is not free.
module xml_entity_decoder_utf8_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       run_done,
    output logic       text_done
);

    xed_pkg::xed_cmd_t cmd;
    xed_pkg::xed_sts_t sts;

    // Sequencer for scanning, parsing and emission.
    xed_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Held-byte memory, parser and output registers.
    xed_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .data_byte (data_byte),
        .in_last   (in_last),
        .cmd       (cmd),
        .sts       (sts),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_byte  (out_byte),
        .run_done  (run_done),
        .text_done (text_done)
    );

endmodule
